// ===== design/bba_pkg.sv =====
// Shared types, constants and helper function of the bitmap block allocator.
package bba_pkg;

  localparam int unsigned BITMAP_BYTES = 128 * 1024;
  localparam int unsigned WORD_W       = 32;
  localparam int unsigned WORD_BYTES   = WORD_W / 8;
  localparam int unsigned WORDS        = BITMAP_BYTES / WORD_BYTES;
  localparam int unsigned WORD_AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned WORD_SH      = $clog2(WORD_W);
  localparam int unsigned BLK_W        = 20;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned ST_W         = 2;
  localparam int unsigned DATA_W       = ((BLK_W + 7) / 8) * 8;

  localparam logic [BLK_W:0]   TOTAL_BLOCKS = (BLK_W + 1)'(BITMAP_BYTES * 8);
  localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(WORDS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_FIND      = 2'd0,
    OP_MARK_USED = 2'd1,
    OP_MARK_FREE = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK_RD,
    S_MARK_WR,
    S_FIND_RD,
    S_FIND_CHK,
    S_RESP
  } state_e;

  // Position of the first zero bit counted from the most significant end.
  function automatic logic [WORD_SH-1:0] first_zero(input logic [WORD_W-1:0] w);
    logic [WORD_SH-1:0] idx;
    idx = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (!w[WORD_W-1-k]) begin
        idx = WORD_SH'(k);
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/bba_ram.sv =====
// Single-port bitmap RAM with registered read data, read-before-write.
module bba_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bitmap_block_allocator.sv =====
// Top level of the bitmap block allocator: request sequencer, scan hint and result register.
//
// The allocator keeps a usage bitmap of 1M blocks (a 1 bit marks a block in use, bits
// numbered most significant first inside each byte) in a single-port RAM of 32-bit
// words. Each request either finds the lowest free block, marks one block used, or marks
// one block free, and each request returns exactly one result carrying the block number
// and a status (done, block number out of range, or no free block). After reset the
// allocator first sweeps the RAM to zero, one word per cycle; s_axis_tready stays low
// during that pass. A mark request then passes through a RAM read state, a RAM write
// state and a hand-over state in which its result is loaded, after which the allocator
// is ready again. A find request scans words through the same RAM port starting at a
// hint register that points at the lowest word that may still hold a free bit, spending
// a read state and a check state on each scanned word before the hand-over state loads
// its result; when blocks are allocated in order the hint keeps the scan mostly to a
// single word. Freeing a block pulls the hint back down to that block's word. Operation
// code three is accepted and answered from the hand-over state with the block number
// echoed and status done. The hand-over state holds for as long as a previous result
// waits on m_axis_tready. The result sits in an output register, so one finished
// result may wait on m_axis_tready while the next request is already accepted.
module bitmap_block_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request channel.
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [bba_pkg::DATA_W-1:0] s_axis_tdata,   // [19:0] block_number, rest zero
  input  logic [bba_pkg::OP_W-1:0]   s_axis_tuser,   // [1:0] operation
  // Result channel.
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [bba_pkg::DATA_W-1:0] m_axis_tdata,   // [19:0] result_block, rest zero
  output logic [bba_pkg::ST_W-1:0]   m_axis_tuser    // [1:0] status
);

  import bba_pkg::*;

  state_e              state_q, state_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [BLK_W-1:0]    blk_q, blk_d;
  logic [WORD_AW-1:0]  addr_q, addr_d;
  logic [WORD_AW-1:0]  hint_q, hint_d;
  logic [BLK_W-1:0]    res_q, res_d;
  status_e             st_q, st_d;
  logic                out_valid_q, out_valid_d;
  logic [BLK_W-1:0]    out_blk_q, out_blk_d;
  status_e             out_st_q, out_st_d;

  logic                ram_we;
  logic [WORD_W-1:0]   ram_wdata;
  logic [WORD_W-1:0]   ram_rdata;

  logic                in_accept;
  logic                out_load;
  logic [BLK_W-1:0]    in_blk;
  logic                in_range_err;
  logic [WORD_AW-1:0]  blk_word;
  logic [WORD_W-1:0]   blk_mask;
  logic                word_full;

  assign in_blk       = s_axis_tdata[BLK_W-1:0];
  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign in_range_err = {1'b0, in_blk} >= TOTAL_BLOCKS;
  assign blk_word     = WORD_AW'(blk_q >> WORD_SH);
  assign blk_mask     = {1'b1, {(WORD_W-1){1'b0}}} >> blk_q[WORD_SH-1:0];
  assign word_full    = &ram_rdata;
  assign out_load     = (state_q == S_RESP) && (!out_valid_q || m_axis_tready);

  assign s_axis_tready = (state_q == S_IDLE);

  // Next-state logic of the request sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (addr_q == LAST_WORD) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          case (s_axis_tuser) inside
            OP_FIND: state_d = S_FIND_RD;
            OP_MARK_USED, OP_MARK_FREE: begin
              state_d = in_range_err ? S_RESP : S_MARK_RD;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_MARK_RD:  state_d = S_MARK_WR;
      S_MARK_WR:  state_d = S_RESP;
      S_FIND_RD:  state_d = S_FIND_CHK;
      S_FIND_CHK: begin
        if (!word_full || addr_q == LAST_WORD) begin
          state_d = S_RESP;
        end else begin
          state_d = S_FIND_RD;
        end
      end
      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM controls driven by the sequencer state.
  always_comb begin
    op_d        = op_q;
    blk_d       = blk_q;
    addr_d      = addr_q;
    hint_d      = hint_q;
    res_d       = res_q;
    st_d        = st_q;
    ram_we      = 1'b0;
    ram_wdata   = '0;
    out_blk_d   = out_blk_q;
    out_st_d    = out_st_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        addr_d = addr_q + 1'b1;
      end
      S_IDLE: begin
        if (in_accept) begin
          op_d  = s_axis_tuser;
          blk_d = in_blk;
          res_d = in_blk;
          st_d  = ST_DONE;
          case (s_axis_tuser) inside
            OP_FIND: addr_d = hint_q;
            OP_MARK_USED, OP_MARK_FREE: begin
              addr_d = WORD_AW'(in_blk >> WORD_SH);
              if (in_range_err) begin
                st_d = ST_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      S_MARK_RD: ;
      S_MARK_WR: begin
        ram_we = 1'b1;
        if (op_q == OP_MARK_USED) begin
          ram_wdata = ram_rdata | blk_mask;
        end else begin
          ram_wdata = ram_rdata & ~blk_mask;
          // Every word below the hint must stay full, so freeing pulls it down.
          if (blk_word < hint_q) begin
            hint_d = blk_word;
          end
        end
      end
      S_FIND_RD: ;
      S_FIND_CHK: begin
        if (!word_full) begin
          res_d  = BLK_W'({addr_q, first_zero(ram_rdata)});
          st_d   = ST_DONE;
          hint_d = addr_q;
        end else if (addr_q == LAST_WORD) begin
          res_d  = '0;
          st_d   = ST_FULL;
          hint_d = addr_q;
        end else begin
          addr_d = addr_q + 1'b1;
        end
      end
      S_RESP: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_blk_d   = res_q;
          out_st_d    = st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    blk_q     <= blk_d;
    res_q     <= res_d;
    st_q      <= st_d;
    out_blk_q <= out_blk_d;
    out_st_q  <= out_st_d;
  end

  bba_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_W),
    .AW    (WORD_AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DATA_W'(out_blk_q);
  assign m_axis_tuser  = out_st_q;

endmodule

// ===== test/bitmap_block_allocator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench that streams allocator requests and checks every result.
module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int unsigned BLOCK_COUNT  = BITMAP_BYTES * 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_REQS  = 2000;
  // The limit leaves plenty of room above the clearing sweep after reset and above
  // a find that scans the whole bitmap.
  localparam int unsigned IDLE_LIMIT   = 200000;
  localparam int unsigned HOLD_AT      = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned ALLOC_WRAP   = 2048;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [BLK_W-1:0] blk;
  } alloc_req_t;

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_e          st;
  } alloc_res_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic [OP_W-1:0]   s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [DATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]   m_axis_tuser;

  bitmap_block_allocator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // Requests waiting to be offered, and results owed by the allocator.
  alloc_req_t request_backlog[$];
  alloc_res_t owed_results[$];

  // Shadow of the usage bitmap, one entry per block. free_floor is a lower
  // bound on the lowest free block, so a find need not start from zero.
  bit          block_used [BLOCK_COUNT];
  int unsigned free_floor = 0;

  int unsigned mismatch_count = 0;
  int unsigned reqs_accepted  = 0;
  int unsigned results_seen   = 0;
  int unsigned total_reqs     = 0;
  int unsigned find_count     = 0;
  int unsigned used_count     = 0;
  int unsigned freed_count    = 0;
  int unsigned unused_count   = 0;
  int unsigned deepest_found  = 0;
  int unsigned idle_cycles    = 0;

  // Applies one request to the shadow bitmap and returns the result it must produce.
  function automatic alloc_res_t allocator_outcome(alloc_req_t r);
    alloc_res_t  res;
    int unsigned b;
    res.blk = r.blk;
    res.st  = ST_DONE;
    if (r.op == OP_FIND) begin
      b = free_floor;
      while (b < BLOCK_COUNT && block_used[b]) begin
        b++;
      end
      free_floor = b;
      if (b < BLOCK_COUNT) begin
        res.blk = BLK_W'(b);
      end else begin
        res.blk = '0;
        res.st  = ST_FULL;
      end
    end else if (r.op == OP_MARK_USED || r.op == OP_MARK_FREE) begin
      if (r.blk >= BLOCK_COUNT) begin
        res.st = ST_RANGE;
      end else if (r.op == OP_MARK_USED) begin
        block_used[r.blk] = 1'b1;
      end else begin
        block_used[r.blk] = 1'b0;
        if (r.blk < free_floor) begin
          free_floor = r.blk;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic enqueue_request(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk);
    alloc_req_t r;
    r.op  = op;
    r.blk = blk;
    request_backlog.push_back(r);
  endtask

  // Request driver. The gap before each request is drawn when the previous one
  // is accepted; in burst stretches there is no gap at all.
  alloc_req_t  taken_req;
  alloc_req_t  next_req;
  alloc_res_t  taken_res;
  bit          sent_now;
  bit          send_burst = 1'b0;
  int unsigned send_wait  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      send_wait     = 0;
    end else begin
      sent_now = s_axis_tvalid && s_axis_tready;
      if (sent_now) begin
        taken_req.op  = s_axis_tuser;
        taken_req.blk = s_axis_tdata[BLK_W-1:0];
        taken_res     = allocator_outcome(taken_req);
        owed_results.push_back(taken_res);
        reqs_accepted++;
        case (taken_req.op)
          OP_FIND: begin
            find_count++;
            if (taken_res.st == ST_DONE && taken_res.blk > deepest_found) begin
              deepest_found = taken_res.blk;
            end
          end
          OP_MARK_USED: used_count++;
          OP_MARK_FREE: freed_count++;
          default:      unused_count++;
        endcase
        if ($urandom_range(0, 63) == 0) begin
          send_burst = !send_burst;
        end
        send_wait = send_burst ? 0 : $urandom_range(0, 9);
      end
      if (s_axis_tvalid && !sent_now) begin
        // Request still on offer: hold it steady.
      end else if (send_wait != 0) begin
        send_wait--;
        s_axis_tvalid <= 1'b0;
      end else if (request_backlog.size() != 0) begin
        next_req = request_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(next_req.blk);
        s_axis_tuser  <= next_req.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor. Besides the short random stalls, it holds off once for a
  // long stretch so that the allocator backs up and stops taking requests.
  alloc_res_t  want_res;
  bit          got_now;
  bit          recv_burst = 1'b0;
  int unsigned recv_wait  = 0;
  int unsigned hold_left  = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     = 0;
      hold_left     = 0;
    end else begin
      got_now = m_axis_tvalid && m_axis_tready;
      if (got_now) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result, block %0d status %0d",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          want_res = owed_results.pop_front();
          if (m_axis_tdata !== DATA_W'(want_res.blk)) begin
            report_mismatch($sformatf("result %0d: block %0d, expected %0d",
                                      results_seen, m_axis_tdata, want_res.blk));
          end
          if (m_axis_tuser !== want_res.st) begin
            report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                      results_seen, m_axis_tuser, want_res.st));
          end
        end
        if (results_seen == HOLD_AT) begin
          hold_left = HOLD_CYCLES;
        end
        if ($urandom_range(0, 63) == 0) begin
          recv_burst = !recv_burst;
        end
        recv_wait = recv_burst ? 0 : $urandom_range(0, 9);
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a stretch with no request and no result accepted ends the run.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("bitmap_block_allocator_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned next_blk;
    int unsigned run_kind;
    int unsigned run_len;
    int unsigned stim_goal;

    // Directed part: empty-bitmap find, both block extremes, repeated marks,
    // the unused operation code, a full first byte and a free below the last block found.
    enqueue_request(OP_FIND, '0);
    enqueue_request(OP_UNUSED, '1);
    enqueue_request(OP_UNUSED, '0);
    enqueue_request(OP_MARK_USED, '0);
    enqueue_request(OP_FIND, '1);
    enqueue_request(OP_MARK_USED, '0);
    enqueue_request(OP_MARK_FREE, 20'd5);
    enqueue_request(OP_MARK_USED, '1);
    enqueue_request(OP_MARK_FREE, '1);
    enqueue_request(OP_MARK_USED, '1);
    for (int b = 1; b < 8; b++) begin
      enqueue_request(OP_MARK_USED, BLK_W'(b));
    end
    enqueue_request(OP_FIND, 20'h55555);
    enqueue_request(OP_MARK_FREE, 20'd3);
    enqueue_request(OP_FIND, 20'hAAAAA);
    enqueue_request(OP_MARK_USED, 20'd3);
    enqueue_request(OP_MARK_FREE, '0);
    enqueue_request(OP_FIND, '0);
    enqueue_request(OP_MARK_USED, '0);

    // Random part, mostly in-order allocation (find, then mark the next block)
    // mixed with frees at or below the allocation point and a share of noise.
    next_blk  = 8;
    stim_goal = request_backlog.size() + RANDOM_REQS;
    while (request_backlog.size() < stim_goal) begin
      run_kind = $urandom_range(0, 9);
      run_len  = $urandom_range(1, 12);
      for (int i = 0; i < run_len; i++) begin
        if (run_kind < 5) begin
          enqueue_request(OP_FIND, BLK_W'($urandom));
          enqueue_request(OP_MARK_USED, BLK_W'(next_blk));
          next_blk++;
          if (next_blk >= ALLOC_WRAP) begin
            next_blk = $urandom_range(0, 63);
          end
        end else if (run_kind < 7) begin
          enqueue_request(OP_MARK_FREE, BLK_W'($urandom_range(0, next_blk)));
        end else if (run_kind < 9) begin
          enqueue_request($urandom_range(0, 1) ? OP_MARK_USED : OP_MARK_FREE,
                          BLK_W'($urandom_range(0, 255)));
        end else begin
          enqueue_request(OP_W'($urandom_range(0, 3)), BLK_W'($urandom));
        end
      end
    end
    total_reqs = request_backlog.size();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (reqs_accepted != total_reqs || owed_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d finds (lowest free reached block %0d), %0d marks used,",
             reqs_accepted, find_count, deepest_found, used_count);
    $display("%0d marks free, %0d unused-code requests; one %0d-cycle result stall applied.",
             freed_count, unused_count, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("bitmap_block_allocator_tb OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("bitmap_block_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/bba_pkg.sv
design/bba_ram.sv
design/bitmap_block_allocator.sv
test/bitmap_block_allocator_tb.sv
